### hdl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg: shared types, constants and code-mapping functions
// Register indexes, mapping modes, result item layout and the two
// pattern classifiers (uniform, minimal rotation).
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int PIXEL_W = 8;
  localparam int POS_W   = 11;
  localparam int CFG_W   = 12;
  localparam int REG_IDX_W = 2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAPPING_MODE     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_NEIGHBOUR_OFFSET = 2'd3;

  // mapping modes
  localparam logic [1:0] MODE_RAW     = 2'd0;
  localparam logic [1:0] MODE_UNIFORM = 2'd1;
  localparam logic [1:0] MODE_MINROT  = 2'd2;
  localparam logic [1:0] MODE_BOTH    = 2'd3;

  // reset values
  localparam logic [CFG_W-1:0]   RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0]   RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [1:0]         RST_MAPPING_MODE = MODE_UNIFORM;
  localparam logic [PIXEL_W-1:0] RST_OFFSET       = 8'd0;

  localparam logic [CFG_W-1:0] MIN_DIM    = 12'd3;
  localparam logic [CFG_W-1:0] MAX_HEIGHT = 12'd2048;

  // output queue
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  typedef struct packed {
    logic [PIXEL_W-1:0] pattern_code;
    logic [POS_W-1:0]   center_row;
    logic [POS_W-1:0]   center_col;
  } result_t;

  // at most two circular 0/1 transitions
  function automatic logic is_uniform(input logic [7:0] code);
    logic [7:0] hops;
    logic [3:0] n;
    hops = code ^ {code[0], code[7:1]};
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'd0, hops[k]};
    end
    return (n <= 4'd2);
  endfunction

  // code is not above any of its rotations
  function automatic logic is_min_rotation(input logic [7:0] code);
    logic [15:0] dbl;
    logic [7:0]  rot;
    logic        ok;
    dbl = {code, code};
    ok  = 1'b1;
    for (int s = 1; s < 8; s++) begin
      rot = dbl[s +: 8];
      if (rot < code) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [7:0] map_code(input logic [7:0] code, input logic [1:0] mode);
    logic keep;
    case (mode)
      MODE_RAW:     keep = 1'b1;
      MODE_UNIFORM: keep = is_uniform(code);
      MODE_MINROT:  keep = is_min_rotation(code);
      MODE_BOTH:    keep = is_uniform(code) && is_min_rotation(code);
      default:      keep = 1'b0;
    endcase
    return keep ? code : 8'd0;
  endfunction

endpackage

### hdl/lbp_line_mem.sv
// ----------------------------------------------------------------------------
// lbp_line_mem: line buffer memory
// One word per column holding both row banks; one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module lbp_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/lbp_code_unit.sv
// ----------------------------------------------------------------------------
// lbp_code_unit: 3x3 window and pattern coder
// Holds the two previous window columns, forms the 8-bit pattern for
// the center and maps it by mode.
// ----------------------------------------------------------------------------
module lbp_code_unit
  import lbp_pkg::*;
#(
  parameter int CW = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [PIXEL_W-1:0] top,
  input  logic [PIXEL_W-1:0] mid,
  input  logic [PIXEL_W-1:0] bot,
  input  logic [POS_W-1:0]   row,
  input  logic [CW-1:0]      col,
  input  logic [1:0]         mode,
  input  logic [PIXEL_W-1:0] offset,
  output logic               emit,
  output result_t            result
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // [0..2] column c-2 rows r-2..r, [3..5] column c-1
  logic [PIXEL_W-1:0] win_r [6];
  logic [PIXEL_W-1:0] center;
  logic [PIXEL_W-1:0] nb [8];
  logic [7:0]         code;
  logic [PW-1:0]      col_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (step) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot;
    end
  end

  // bit 0 left, then counter-clockwise from bottom-left to top-left
  always_comb begin
    center = win_r[4];
    nb[0] = win_r[1];
    nb[1] = win_r[2];
    nb[2] = win_r[5];
    nb[3] = bot;
    nb[4] = mid;
    nb[5] = top;
    nb[6] = win_r[3];
    nb[7] = win_r[0];
    for (int k = 0; k < 8; k++) begin
      code[k] = ((nb[k] - offset) >= center);
    end
  end

  assign emit   = step && (row >= POS_W'(2)) && (col >= CW'(2));
  assign col_m1 = PW'(col) - PW'(1);

  assign result.pattern_code = map_code(code, mode);
  assign result.center_row   = row - POS_W'(1);
  assign result.center_col   = col_m1[POS_W-1:0];

endmodule

### hdl/lbp_out_fifo.sv
// ----------------------------------------------------------------------------
// lbp_out_fifo: result item queue
// Small register queue between the coder and the output channel.
// ----------------------------------------------------------------------------
module lbp_out_fifo
  import lbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  result_t               push_data,
  input  logic                  pop,
  output logic                  not_empty,
  output result_t               head,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t               q_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

### hdl/lbp_3x3_pattern_coder_top.sv
// ----------------------------------------------------------------------------
// lbp_3x3_pattern_coder_top: 3x3 local binary pattern coder
// Raster pixel stream in, one mapped pattern code per interior pixel out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one 8-bit pixel per item, raster order, row-major.
//   out_*  : one item per interior center: mapped code plus its row and
//            column. Border centers give no item; the consumer fills them.
//   cfg_*  : register writes (0 width, 1 height, 2 mapping mode,
//            3 neighbour offset); cfg_ready is always high. Write only
//            while the block is idle.
//   Pipeline: an accepted pixel is registered in the read stage along with
//            its line-memory word, is coded combinationally and is then
//            written into the output queue, where its item becomes visible.
//   Throughput: one pixel per cycle while in_ready is high, set by one
//            line-memory read and write per pixel; a word holds both row banks.
//   Stall: a 3-entry output queue sits behind the coder. in_ready drops
//            when queue entries plus the pixel in flight reach 3, so a
//            stalled receiver holds the input once two items wait with a
//            pixel in flight behind them, or three items wait.
//   Reset: registers return to 640x480, uniform mode, offset 0; counters
//            and window clear. The line memory is not cleared: the first
//            two rows of a frame fill it before any center is coded.
// ----------------------------------------------------------------------------
module lbp_3x3_pattern_coder_top
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIXEL_W-1:0]   in_pixel,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIXEL_W-1:0]   out_pattern_code,
  output logic [POS_W-1:0]     out_center_row,
  output logic [POS_W-1:0]     out_center_col,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;   // column bits
  localparam int EW = ((CW + 1) > CFG_W) ? (CW + 1) : CFG_W;    // width compare
  localparam int DW = 2 * PIXEL_W;

  // configuration
  logic [CFG_W-1:0]   image_width_r;
  logic [CFG_W-1:0]   image_height_r;
  logic [1:0]         mapping_mode_r;
  logic [PIXEL_W-1:0] neighbour_offset_r;

  // raster counters
  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [POS_W-1:0] row_cnt_r, row_cnt_nxt;

  // effective frame size
  logic [EW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h;
  logic [CW-1:0]    col_cur;
  logic [POS_W-1:0] row_cur;
  logic [EW-1:0]    col_inc;
  logic [CFG_W-1:0] row_inc;

  // read stage
  logic               s1_valid_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic [CW-1:0]      s1_col_r;
  logic [POS_W-1:0]   s1_row_r;

  logic               in_fire;
  logic [DW-1:0]      rd_word;
  logic [PIXEL_W-1:0] top, mid;
  logic [DW-1:0]      wr_word;

  logic               emit;
  result_t            result;
  result_t            head;
  logic [FIFO_CNT_W-1:0] q_count;
  logic [2:0]         occupancy;

  // --- configuration port ---
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r      <= RST_IMAGE_WIDTH;
      image_height_r     <= RST_IMAGE_HEIGHT;
      mapping_mode_r     <= RST_MAPPING_MODE;
      neighbour_offset_r <= RST_OFFSET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:      image_width_r      <= cfg_data;
        REG_IMAGE_HEIGHT:     image_height_r     <= cfg_data;
        REG_MAPPING_MODE:     mapping_mode_r     <= cfg_data[1:0];
        REG_NEIGHBOUR_OFFSET: neighbour_offset_r <= cfg_data[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // --- clamp frame size: below 3 acts as 3, above the limit as the limit ---
  always_comb begin
    if (image_width_r < MIN_DIM) begin
      eff_w = EW'(MIN_DIM);
    end else if (EW'(image_width_r) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width_r);
    end
    if (image_height_r < MIN_DIM) begin
      eff_h = MIN_DIM;
    end else if (image_height_r > MAX_HEIGHT) begin
      eff_h = MAX_HEIGHT;
    end else begin
      eff_h = image_height_r;
    end
  end

  // --- raster position; counters past a shrunk frame restart at zero ---
  always_comb begin
    col_cur = (EW'(col_cnt_r) >= eff_w) ? '0 : col_cnt_r;
    row_cur = (CFG_W'(row_cnt_r) >= eff_h) ? '0 : row_cnt_r;
    col_inc = EW'(col_cur) + EW'(1);
    row_inc = CFG_W'(row_cur) + CFG_W'(1);
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_fire) begin
      if (col_inc >= eff_w) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (row_inc >= eff_h) ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_cnt_nxt = col_inc[CW-1:0];
        row_cnt_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // --- input handshake: room for the pixel in flight plus queue entries ---
  assign occupancy = 3'(q_count) + 3'(s1_valid_r);
  assign in_ready  = (occupancy < 3'(FIFO_DEPTH));
  assign in_fire   = in_valid && in_ready;

  // --- read stage: memory word for this column arrives next cycle ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r <= in_pixel;
      s1_col_r   <= col_cur;
      s1_row_r   <= row_cur;
    end
  end

  // word = {bank 1, bank 0}; bank (row & 1) holds row r-2, the other row r-1.
  // Consecutive pixels never share a column, so the write-back of one pixel
  // and the read of the next never hit the same word.
  assign top = s1_row_r[0] ? rd_word[DW-1:PIXEL_W] : rd_word[PIXEL_W-1:0];
  assign mid = s1_row_r[0] ? rd_word[PIXEL_W-1:0]  : rd_word[DW-1:PIXEL_W];
  assign wr_word = s1_row_r[0] ? {s1_pixel_r, mid} : {mid, s1_pixel_r};

  lbp_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (DW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_cur),
    .rd_data (rd_word),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (wr_word)
  );

  lbp_code_unit #(
    .CW (CW)
  ) u_code (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_valid_r),
    .top    (top),
    .mid    (mid),
    .bot    (s1_pixel_r),
    .row    (s1_row_r),
    .col    (s1_col_r),
    .mode   (mapping_mode_r),
    .offset (neighbour_offset_r),
    .emit   (emit),
    .result (result)
  );

  lbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (result),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_pattern_code = head.pattern_code;
  assign out_center_row   = head.center_row;
  assign out_center_col   = head.center_col;

endmodule

### tb/sv/lbp_3x3_pattern_coder_top_tb.sv
// ----------------------------------------------------------------------------
// lbp_3x3_pattern_coder_top_tb: self-checking bench for the 3x3 LBP coder
// Streams raster pixel frames through the valid/ready input and compares every
// result item with a cycle-free model of the line buffers, the window and the
// code mapping. Covers register defaults, clamped sizes, resizing inside a
// frame and random frames under random idling on both sides.
// ----------------------------------------------------------------------------
module lbp_3x3_pattern_coder_top_tb;
  import lbp_pkg::*;

  localparam int          LINE_MAX       = 2048;  // DUT MAX_WIDTH
  localparam int unsigned HEIGHT_MAX     = 2048;
  localparam int          PIPE_DRAIN     = 4;     // extra wait once no item is pending
  localparam int          TAIL_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PRINT_CAP      = 100;

  // how test pixels are made
  typedef enum int {
    STYLE_NOISE,  // any value
    STYLE_FLAT,   // base plus tiny noise: lots of uniform codes
    STYLE_EDGE    // diagonal stripes: edge and corner codes
  } pixel_style_e;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [PIXEL_W-1:0]   in_pixel  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIXEL_W-1:0]   out_pattern_code;
  logic [POS_W-1:0]     out_center_row;
  logic [POS_W-1:0]     out_center_col;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // idling knobs, percent per cycle
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatch_count = 0;

  // model state: registers, line banks, window, position of the next pixel
  logic [CFG_W-1:0]   cur_width  = RST_IMAGE_WIDTH;
  logic [CFG_W-1:0]   cur_height = RST_IMAGE_HEIGHT;
  logic [1:0]         cur_mode   = RST_MAPPING_MODE;
  logic [PIXEL_W-1:0] cur_offset = RST_OFFSET;
  logic [7:0]         line_mem [0:2*LINE_MAX-1];
  logic [7:0]         win_col [0:5];
  int unsigned        next_col = 0;
  int unsigned        next_row = 0;

  // expected result items, oldest first
  result_t pending_codes [$];
  result_t want_code;

  lbp_3x3_pattern_coder_top #(
    .MAX_WIDTH(LINE_MAX)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pattern_code (out_pattern_code),
    .out_center_row   (out_center_row),
    .out_center_col   (out_center_col),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // sizes below 3 act as 3, oversize clamps to the max
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned hi);
    if (v < MIN_DIM) return 32'(MIN_DIM);
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // keep or zero the raw code per mapping mode
  function automatic logic [7:0] apply_mode(input logic [7:0] code, input logic [1:0] mode);
    int unsigned hops;
    logic [7:0]  rot;
    logic [7:0]  least;
    logic        uni;
    logic        minrot;
    logic        keep;
    hops = 0;
    for (int k = 0; k < 8; k++) begin
      if (code[k] != code[(k + 1) % 8]) hops++;
    end
    uni = (hops <= 2);
    rot = code;
    least = code;
    for (int s = 1; s < 8; s++) begin
      rot = {rot[6:0], rot[7]};
      if (rot < least) least = rot;
    end
    minrot = (least == code);
    case (mode)
      MODE_RAW:     keep = 1'b1;
      MODE_UNIFORM: keep = uni;
      MODE_MINROT:  keep = minrot;
      default:      keep = uni && minrot;
    endcase
    return keep ? code : 8'd0;
  endfunction

  // next pixel lands on row 0, column 0 (counters may sit past a shrunk size)
  function automatic logic at_frame_start();
    int unsigned w;
    int unsigned h;
    w = clamp_dim(cur_width, LINE_MAX);
    h = clamp_dim(cur_height, HEIGHT_MAX);
    return (next_col == 0 || next_col >= w) && (next_row == 0 || next_row >= h);
  endfunction

  // advance the model by one accepted pixel; queue the item it causes
  task automatic code_pixel(input logic [7:0] px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     c;
    int unsigned     r;
    logic [7:0]      top;
    logic [7:0]      mid;
    logic [7:0]      ctr;
    logic [7:0]      diff;
    logic [7:0][7:0] nbr;
    logic [7:0]      raw;
    result_t         res;
    w = clamp_dim(cur_width, LINE_MAX);
    h = clamp_dim(cur_height, HEIGHT_MAX);
    c = (next_col >= w) ? 0 : next_col;
    r = (next_row >= h) ? 0 : next_row;
    // banks alternate by row parity: top is row r-2, mid is row r-1
    top = line_mem[(r % 2) * LINE_MAX + c];
    mid = line_mem[((r + 1) % 2) * LINE_MAX + c];
    if (r >= 2 && c >= 2) begin
      ctr = win_col[4];
      // bit 0 left, then counter-clockwise to bit 7 top-left
      nbr = {win_col[0], win_col[3], top, mid, px, win_col[5], win_col[2], win_col[1]};
      for (int k = 0; k < 8; k++) begin
        diff   = nbr[k] - cur_offset;
        raw[k] = (diff >= ctr);
      end
      res.pattern_code = apply_mode(raw, cur_mode);
      res.center_row   = POS_W'(r - 1);
      res.center_col   = POS_W'(c - 1);
      pending_codes.push_back(res);
    end
    win_col[0] = win_col[3];
    win_col[1] = win_col[4];
    win_col[2] = win_col[5];
    win_col[3] = top;
    win_col[4] = mid;
    win_col[5] = px;
    line_mem[(r % 2) * LINE_MAX + c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // outputs sampled before the edge updates them
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("item with nothing pending, code", out_pattern_code, 0);
      end else begin
        want_code = pending_codes.pop_front();
        if (out_pattern_code !== want_code.pattern_code)
          report_mismatch("pattern_code", out_pattern_code, want_code.pattern_code);
        if (out_center_row !== want_code.center_row)
          report_mismatch("center_row", out_center_row, want_code.center_row);
        if (out_center_col !== want_code.center_col)
          report_mismatch("center_col", out_center_col, want_code.center_col);
      end
    end
  end

  // ends the run if nothing moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("lbp_3x3_pattern_coder_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // one pixel item; valid stays high on return so back-to-back items don't
  // drop it. Anything that stops sending goes through wait_idle.
  task automatic send_pixel(input logic [7:0] px);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    code_pixel(px);
  endtask

  // stop sending, collect all pending items, let the pipe empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:      cur_width  = data;
      REG_IMAGE_HEIGHT:     cur_height = data;
      REG_MAPPING_MODE:     cur_mode   = data[1:0];
      REG_NEIGHBOUR_OFFSET: cur_offset = data[PIXEL_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] make_pixel(input pixel_style_e style, input logic [7:0] base);
    case (style)
      STYLE_FLAT: return base + 8'($urandom_range(0, 3));
      STYLE_EDGE: return ((((next_col + next_row) % 6) < 3) ? base : ~base)
                         ^ 8'($urandom_range(0, 1));
      default:    return 8'($urandom);
    endcase
  endfunction

  // send until the model's position wraps back to the frame origin
  task automatic send_rest_of_frame(input pixel_style_e style, input logic [7:0] base,
                                    output int unsigned n);
    n = 0;
    do begin
      send_pixel(make_pixel(style, base));
      n++;
    end while (!at_frame_start());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // uniform mode and zero offset straight out of reset, on small frames of
  // nearly flat pixels so that many codes are uniform
  task automatic test_reset_defaults();
    int unsigned n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_IMAGE_WIDTH, 12'd6);
    write_reg(REG_IMAGE_HEIGHT, 12'd4);
    for (int f = 0; f < 2; f++) send_rest_of_frame(STYLE_FLAT, 8'($urandom), n);
  endtask

  // width 1 and height 2 both act as 3: nine pixels per frame, one item.
  // Frames: all equal, bright center on dark ring, bright top row.
  task automatic test_directed_patterns();
    logic [7:0] px;
    write_reg(REG_IMAGE_WIDTH, 12'd1);
    write_reg(REG_IMAGE_HEIGHT, 12'd2);
    write_reg(REG_MAPPING_MODE, {10'd0, MODE_RAW});
    write_reg(REG_NEIGHBOUR_OFFSET, 12'd0);
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < 9; i++) begin
        case (f)
          0:       px = 8'h00;
          1:       px = (i == 4) ? 8'hFF : 8'h00;
          default: px = (i < 3) ? 8'hFF : ((i == 4) ? 8'h80 : 8'h00);
        endcase
        send_pixel(px);
      end
    end
    // offset wraps the zero neighbors to 255 against a bright center
    write_reg(REG_NEIGHBOUR_OFFSET, 12'd1);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFE : 8'h00);
  endtask

  // narrow the row mid-row, then cut the height below the current row
  task automatic test_mid_frame_resize();
    int unsigned n;
    logic [7:0]  base;
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    base = 8'($urandom);
    write_reg(REG_IMAGE_WIDTH, 12'd8);
    write_reg(REG_IMAGE_HEIGHT, 12'd6);
    repeat (8 * 3 + 4) send_pixel(make_pixel(STYLE_EDGE, base));
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    repeat (7) send_pixel(make_pixel(STYLE_EDGE, base));
    write_reg(REG_IMAGE_HEIGHT, 12'd4);
    send_rest_of_frame(STYLE_EDGE, base, n);
  endtask

  // whole small frames with fresh settings each time; modes rotate,
  // upper data bits are junk the block must mask off
  task automatic test_random_frames(input int unsigned send_pct, input int unsigned recv_pct,
                                    input int unsigned item_goal);
    int unsigned  sent;
    int unsigned  n;
    int unsigned  pick;
    logic [CFG_W-1:0] data;
    logic [7:0]   offset;
    pixel_style_e style;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    pick = $urandom_range(0, 3);
    while (sent < item_goal) begin
      write_reg(REG_IMAGE_WIDTH, 12'($urandom_range(0, 12)));
      write_reg(REG_IMAGE_HEIGHT, 12'($urandom_range(0, 7)));
      data = 12'($urandom);
      data[1:0] = pick[1:0];
      write_reg(REG_MAPPING_MODE, data);
      case ($urandom_range(0, 3))
        0:       offset = 8'd0;
        1:       offset = 8'hFF;
        2:       offset = 8'($urandom_range(1, 16));
        default: offset = 8'($urandom);
      endcase
      write_reg(REG_NEIGHBOUR_OFFSET, {4'($urandom), offset});
      style = pixel_style_e'($urandom_range(0, 2));
      send_rest_of_frame(style, 8'($urandom), n);
      sent += n;
      pick++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 6; i++) win_col[i] = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_patterns();
    test_mid_frame_resize();
    test_random_frames(0, 0, 100);
    test_random_frames(71, 0, 100);
    test_random_frames(0, 71, 100);
    test_random_frames(20, 20, 100);

    // collect the rest, then watch for strays with the receiver open
    recv_stall_pct = 0;
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_codes.size() != 0)
      report_mismatch("items never produced, count", pending_codes.size(), 0);

    if (mismatch_count == 0) begin
      $display("lbp_3x3_pattern_coder_top verification clean");
    end else begin
      $display("lbp_3x3_pattern_coder_top verification failed");
    end
    $finish;
  end

endmodule
